// File: hw/rtl/kmd_pkg.sv
// Shared types and constants for the key matrix debouncer.
package kmd_pkg;

    // Default matrix geometry
    localparam int ROWS_DEF = 8;
    localparam int COLS_DEF = 6;

    // Fixed field widths
    localparam int ROW_W   = 3;
    localparam int LEVEL_W = 6;
    localparam int TIME_W  = 32;
    localparam int KEY_W   = 8;
    localparam int MAP_W   = 48;

    localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd5000;

    // Command codes
    localparam logic CMD_SCAN     = 1'b0;
    localparam logic CMD_OVERRIDE = 1'b1;

    // One input beat, unpacked
    typedef struct packed {
        logic               cmd;
        logic [ROW_W-1:0]   row;
        logic [LEVEL_W-1:0] levels;
        logic [TIME_W-1:0]  now_us;
        logic [KEY_W-1:0]   key_num;
        logic               key_pressed;
    } t_kmd_item;

    // One result beat, unpacked
    typedef struct packed {
        logic [LEVEL_W-1:0] row_stable;
        logic [LEVEL_W-1:0] row_changed;
        logic [MAP_W-1:0]   stable_keys;
        logic               override_active;
    } t_kmd_result;

endpackage

// File: hw/rtl/kmd_col_filter.sv
// Debounce decision for one column of the scanned row.
module kmd_col_filter
    import kmd_pkg::*;
(
    input  logic              i_level,
    input  logic              i_stable,
    input  logic [TIME_W-1:0] i_agree,
    input  logic [TIME_W-1:0] i_now,
    input  logic [TIME_W-1:0] i_debounce,
    output logic              o_stable_next,
    output logic              o_agree_we
);

    logic [TIME_W-1:0] w_elapsed;
    logic              w_expired;

    // Wrapping elapsed time since the key last agreed
    assign w_elapsed = i_now - i_agree;
    assign w_expired = w_elapsed > i_debounce;

    // Agreeing level refreshes the time; a differing one flips only once expired
    always_comb begin
        if (i_level == i_stable) begin
            o_stable_next = i_stable;
            o_agree_we    = 1'b1;
        end else if (w_expired) begin
            o_stable_next = i_level;
            o_agree_we    = 1'b1;
        end else begin
            o_stable_next = i_stable;
            o_agree_we    = 1'b0;
        end
    end

endmodule

// File: hw/rtl/kmd_keymap.sv
// Key state store: stable map, agree times, override map and the update per beat.
module kmd_keymap
    import kmd_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_kmd_item         i_item,
    input  logic [TIME_W-1:0] i_debounce,
    output t_kmd_result       o_result
);

    localparam int NKEYS = ROWS * COLS;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int KW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;

    logic [NKEYS-1:0]  r_stable, n_stable;
    logic [NKEYS-1:0]  r_ovr, n_ovr;
    logic              r_on, n_on;
    logic [TIME_W-1:0] r_agree [ROWS][COLS];

    logic              w_row_ok;
    logic              w_key_ok;
    logic [RW-1:0]     w_row_idx;
    logic [KW-1:0]     w_key_idx;
    logic [COLS-1:0]   w_row_cur;
    logic [COLS-1:0]   w_row_next;
    logic [COLS-1:0]   w_filt_stable;
    logic [COLS-1:0]   w_filt_we;
    logic [COLS-1:0]   w_agree_we;

    // Range checks on the row and key fields
    assign w_row_ok  = int'(i_item.row) < ROWS;
    assign w_key_ok  = int'(i_item.key_num) < NKEYS;
    assign w_row_idx = RW'(i_item.row);
    assign w_key_idx = KW'(i_item.key_num);

    assign w_row_cur = w_row_ok ? r_stable[w_row_idx*COLS +: COLS] : '0;

    // One filter per column of the addressed row
    for (genvar c = 0; c < COLS; c++) begin : g_col
        logic w_level;
        if (c < LEVEL_W) begin : g_sampled
            assign w_level = i_item.levels[c];
        end else begin : g_unsampled
            assign w_level = 1'b0;
        end
        kmd_col_filter u_filter (
            .i_level       (w_level),
            .i_stable      (w_row_cur[c]),
            .i_agree       (r_agree[w_row_idx][c]),
            .i_now         (i_item.now_us),
            .i_debounce    (i_debounce),
            .o_stable_next (w_filt_stable[c]),
            .o_agree_we    (w_filt_we[c])
        );
    end

    // Next state for the beat in the input register
    always_comb begin
        n_stable   = r_stable;
        n_ovr      = r_ovr;
        n_on       = r_on;
        w_agree_we = '0;
        if (i_fire) begin
            priority if (i_item.cmd == CMD_OVERRIDE) begin
                if (w_key_ok) begin
                    n_ovr[w_key_idx] = i_item.key_pressed;
                    n_on             = 1'b1;
                end
            end else if (r_on) begin
                n_stable = r_ovr;
            end else if (w_row_ok) begin
                n_stable[w_row_idx*COLS +: COLS] = w_filt_stable;
                w_agree_we                       = w_filt_we;
            end
        end
    end

    assign w_row_next = w_row_ok ? n_stable[w_row_idx*COLS +: COLS] : '0;

    // Result fields, clipped or zero-padded to the fixed output widths
    for (genvar c = 0; c < LEVEL_W; c++) begin : g_out_col
        if (c < COLS) begin : g_have
            assign o_result.row_stable[c]  = w_row_next[c];
            assign o_result.row_changed[c] = w_row_next[c] ^ w_row_cur[c];
        end else begin : g_pad
            assign o_result.row_stable[c]  = 1'b0;
            assign o_result.row_changed[c] = 1'b0;
        end
    end

    for (genvar k = 0; k < MAP_W; k++) begin : g_out_key
        if (k < NKEYS) begin : g_have
            assign o_result.stable_keys[k] = n_stable[k];
        end else begin : g_pad
            assign o_result.stable_keys[k] = 1'b0;
        end
    end

    assign o_result.override_active = n_on;

    // Map and mode registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= '0;
            r_ovr    <= '0;
            r_on     <= 1'b0;
        end else begin
            r_stable <= n_stable;
            r_ovr    <= n_ovr;
            r_on     <= n_on;
        end
    end

    // Agree times, written for the scanned row only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < COLS; c++) begin
                    r_agree[r][c] <= '0;
                end
            end
        end else begin
            for (int c = 0; c < COLS; c++) begin
                if (w_agree_we[c]) begin
                    r_agree[w_row_idx][c] <= i_item.now_us;
                end
            end
        end
    end

endmodule

// File: hw/rtl/key_matrix_debouncer_top.sv
// Top level of the key matrix debouncer: stream ports, beat registers and config.
//
// Debounced ROWS x COLS key matrix. A scan beat (tuser 0) carries one row's
// column levels and a microsecond timestamp; each key whose level has
// disagreed with its stable state for longer than debounce_us flips. An
// override beat (tuser 1) sets one key's override level and from then on
// every scan loads the whole override map. Every beat returns one result:
// the row's stable bits, the columns that flipped and the full key map.
// One beat is taken every cycle unless results stall; a beat goes from the input
// register to the result register, the path being one 32-bit subtract and
// compare per column between the two. No clearing pass after reset. Write
// debounce_us only while no beat is in flight.
module key_matrix_debouncer_top
    import kmd_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write: debounce_us
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // row[2:0], column_levels[8:3], now_us[40:9], key_num[48:41], key_pressed[49]
    input  logic [55:0] s_axis_tdata,
    // command[0]
    input  logic        s_axis_tuser,
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // row_stable[5:0], row_changed[11:6], stable_keys[59:12], override_active[60]
    output logic [63:0] m_axis_tdata
);

    t_kmd_item         r_in;
    logic              r_in_valid;
    t_kmd_result       r_out;
    logic              r_out_valid;
    logic [TIME_W-1:0] r_debounce;
    t_kmd_result       w_result;
    logic              w_fire;

    // Beat moves from input register to result register
    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;
    assign o_cfg_ready   = !r_in_valid;

    // Debounce time register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_debounce <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.cmd         <= s_axis_tuser;
            r_in.row         <= s_axis_tdata[2:0];
            r_in.levels      <= s_axis_tdata[8:3];
            r_in.now_us      <= s_axis_tdata[40:9];
            r_in.key_num     <= s_axis_tdata[48:41];
            r_in.key_pressed <= s_axis_tdata[49];
        end
    end

    kmd_keymap #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_keymap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_item     (r_in),
        .i_debounce (r_debounce),
        .o_result   (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.override_active, r_out.stable_keys,
                            r_out.row_changed, r_out.row_stable};

    // Every processed beat lands in the result register
    a_fire_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed beat did not reach the result register");

    // Override mode never drops once reported
    a_override_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_out_valid && r_out.override_active) |-> w_result.override_active)
        else $error("override mode cleared");

    // An override beat never flips a stable key
    a_override_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.cmd == CMD_OVERRIDE) |-> (w_result.row_changed == '0))
        else $error("override beat reported a change");

    // A stalled input beat is kept
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> r_in_valid)
        else $error("stalled input beat lost");

endmodule
